// ----- src/assert_macros.svh -----
// Assertion helpers for the RTL. Both expect clk in scope; FFTR2_ASSERT also expects rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checked only while the block is out of reset.
`define FFTR2_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define FFTR2_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FFTR2_ASSERT(lbl, prop, msg)
`define FFTR2_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ----- src/fftr2_pkg.sv -----
`timescale 1ns / 1ps
package fftr2_pkg;

  // Bin numbers are carried on three bits whatever the frame size.
  localparam int IDX_W = 3;
  // Up to three butterfly stages.
  localparam int STG_W = 2;

  // 1/sqrt2 in Q15 and the rounding offset for a Q15 product.
  localparam int FRAC_BITS = 15;
  localparam logic signed [16:0] TWIDDLE_Q15 = 17'sd23170;
  localparam logic signed [16:0] ROUND_HALF = 17'sd16384;

  // Twiddle applied to the lower leg of a butterfly, as a power of W8.
  typedef enum logic [1:0] {
    TW_ONE   = 2'd0,
    TW_C1    = 2'd1,
    TW_NEG_J = 2'd2,
    TW_C3    = 2'd3
  } fftr2_tw_t;

  typedef struct packed {
    logic             load;
    logic             mul;
    logic             add;
    logic             emit;
    logic [IDX_W-1:0] idx;
    logic [STG_W-1:0] stage;
  } fftr2_cmd_t;

  typedef struct packed {
    logic out_free;
  } fftr2_sts_t;

endpackage

// ----- src/fftr2_sample_if.sv -----
`timescale 1ns / 1ps
interface fftr2_sample_if #(
  parameter int SAMPLE_WIDTH = 16
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_real;
  logic signed [SAMPLE_WIDTH-1:0] sample_imag;

  modport source (output valid, output sample_real, output sample_imag, input ready);
  modport sink (input valid, input sample_real, input sample_imag, output ready);
endinterface

// ----- src/fftr2_bin_if.sv -----
`timescale 1ns / 1ps
interface fftr2_bin_if #(
  parameter int BIN_WIDTH = 19
) ();
  logic                        valid;
  logic                        ready;
  logic signed [BIN_WIDTH-1:0] bin_real;
  logic signed [BIN_WIDTH-1:0] bin_imag;
  logic [2:0]                  bin_index;
  logic                        last_bin;

  modport source (output valid, output bin_real, output bin_imag, output bin_index,
                  output last_bin, input ready);
  modport sink (input valid, input bin_real, input bin_imag, input bin_index,
                input last_bin, output ready);
endinterface

// ----- src/fftr2_ctrl.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fftr2_ctrl
  import fftr2_pkg::*;
#(
  parameter int POINTS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  fftr2_sts_t sts,
  output fftr2_cmd_t cmd
);

  localparam int LOG2N = $clog2(POINTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POINTS - 1);
  localparam logic [STG_W-1:0] LAST_STG = STG_W'(LOG2N - 1);

  typedef enum logic [3:0] {
    ST_LOAD = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_ADD  = 4'b0100,
    ST_EMIT = 4'b1000
  } fftr2_state_t;

  fftr2_state_t     state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [STG_W-1:0] stage_r, stage_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    stage_nxt = stage_r;
    in_ready  = (state_r == ST_LOAD);
    cmd.load  = 1'b0;
    cmd.mul   = 1'b0;
    cmd.add   = 1'b0;
    cmd.emit  = 1'b0;
    cmd.idx   = cnt_r;
    cmd.stage = stage_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (cnt_r == LAST_IDX) begin
            cnt_nxt   = '0;
            state_nxt = ST_MUL;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        cmd.add = 1'b1;
        if (stage_r == LAST_STG) begin
          stage_nxt = '0;
          state_nxt = ST_EMIT;
        end else begin
          stage_nxt = stage_r + 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_EMIT: begin
        // A bin moves into the output register whenever that register is free.
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (cnt_r == LAST_IDX) begin
            cnt_nxt   = '0;
            state_nxt = ST_LOAD;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      stage_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      stage_r <= stage_nxt;
    end
  end

  `FFTR2_ASSERT(a_frame_full, (state_r == ST_LOAD && in_valid && cnt_r == LAST_IDX) |=> (state_r == ST_MUL && cnt_r == '0), "full frame did not start the transform")
  `FFTR2_ASSERT(a_emit_start, (state_r == ST_ADD && stage_r == LAST_STG) |=> (state_r == ST_EMIT && cnt_r == '0 && stage_r == '0), "last stage did not hand over to output")
  `FFTR2_ASSERT_RST(a_reset_load, (!rst_n) |=> (state_r == ST_LOAD && cnt_r == '0), "reset did not return to sample loading")

endmodule

// ----- src/fftr2_datapath.sv -----
`timescale 1ns / 1ps
module fftr2_datapath
  import fftr2_pkg::*;
#(
  parameter int POINTS       = 8,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  fftr2_cmd_t                       cmd,
  output fftr2_sts_t                       sts,
  input  logic signed [SAMPLE_WIDTH-1:0]   sample_real,
  input  logic signed [SAMPLE_WIDTH-1:0]   sample_imag,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [SAMPLE_WIDTH+2:0]   bin_real,
  output logic signed [SAMPLE_WIDTH+2:0]   bin_imag,
  output logic [IDX_W-1:0]                 bin_index,
  output logic                             last_bin
);

  localparam int LOG2N = $clog2(POINTS);
  localparam int BW    = SAMPLE_WIDTH + 3;
  // Two guard bits above the bin width so that saturation sees true overflow.
  localparam int IW    = SAMPLE_WIDTH + 5;
  localparam int AW    = IW + 1;
  localparam int PW    = AW + 17;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POINTS - 1);

  logic signed [IW-1:0] re_r [POINTS];
  logic signed [IW-1:0] im_r [POINTS];
  logic signed [IW-1:0] tre_r [POINTS];
  logic signed [IW-1:0] tim_r [POINTS];
  logic signed [IW-1:0] tre_nxt [POINTS];
  logic signed [IW-1:0] tim_nxt [POINTS];
  logic signed [IW-1:0] re_nxt [POINTS];
  logic signed [IW-1:0] im_nxt [POINTS];
  logic [LOG2N-1:0]     wr_addr;
  logic [LOG2N-1:0]     rd_addr;
  logic signed [IW-1:0] rd_re;
  logic signed [IW-1:0] rd_im;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [BW-1:0] bin_real_r;
  logic signed [BW-1:0] bin_imag_r;
  logic [IDX_W-1:0]     bin_index_r;
  logic                 last_bin_r;

  function automatic logic signed [BW-1:0] sat_bin(input logic signed [IW-1:0] v);
    logic fits;
    fits = (v[IW-1:BW-1] == '0) || (v[IW-1:BW-1] == '1);
    if (fits) begin
      return v[BW-1:0];
    end else if (v[IW-1]) begin
      return {1'b1, {(BW - 1){1'b0}}};
    end else begin
      return {1'b0, {(BW - 1){1'b1}}};
    end
  endfunction

  // Samples land in bit-reversed order so the stages run in place.
  always_comb begin
    for (int k = 0; k < LOG2N; k++) begin
      wr_addr[k] = cmd.idx[LOG2N - 1 - k];
    end
  end

  // Twiddle lanes, one per position; only the lower leg of each pair is used.
  always_comb begin
    logic [IDX_W+1:0]     sh;
    fftr2_tw_t            code;
    logic signed [AW-1:0] arg_re;
    logic signed [AW-1:0] arg_im;
    logic signed [PW-1:0] prod_re;
    logic signed [PW-1:0] prod_im;
    for (int p = 0; p < POINTS; p++) begin
      sh   = {IDX_W'(p), 2'b00} >> cmd.stage;
      code = fftr2_tw_t'(sh[1:0]);
      if (code == TW_C1) begin
        arg_re = AW'(re_r[p]) + AW'(im_r[p]);
        arg_im = AW'(im_r[p]) - AW'(re_r[p]);
      end else begin
        arg_re = AW'(im_r[p]) - AW'(re_r[p]);
        arg_im = -AW'(re_r[p]) - AW'(im_r[p]);
      end
      // Arithmetic shift gives floor, so ties round toward plus infinity.
      prod_re = PW'(arg_re) * PW'(TWIDDLE_Q15) + PW'(ROUND_HALF);
      prod_im = PW'(arg_im) * PW'(TWIDDLE_Q15) + PW'(ROUND_HALF);
      unique case (code)
        TW_ONE: begin
          tre_nxt[p] = re_r[p];
          tim_nxt[p] = im_r[p];
        end
        TW_NEG_J: begin
          tre_nxt[p] = im_r[p];
          tim_nxt[p] = -re_r[p];
        end
        TW_C1, TW_C3: begin
          tre_nxt[p] = prod_re[FRAC_BITS+IW-1:FRAC_BITS];
          tim_nxt[p] = prod_im[FRAC_BITS+IW-1:FRAC_BITS];
        end
      endcase
    end
  end

  // Butterfly lanes: the partner of a position differs in the bit of the stage.
  always_comb begin
    for (int p = 0; p < POINTS; p++) begin
      re_nxt[p] = re_r[p];
      im_nxt[p] = im_r[p];
      for (int s = 0; s < LOG2N; s++) begin
        if (cmd.stage == STG_W'(s)) begin
          if (((p >> s) & 1) == 0) begin
            re_nxt[p] = re_r[p] + tre_r[p ^ (1 << s)];
            im_nxt[p] = im_r[p] + tim_r[p ^ (1 << s)];
          end else begin
            re_nxt[p] = re_r[p ^ (1 << s)] - tre_r[p];
            im_nxt[p] = im_r[p ^ (1 << s)] - tim_r[p];
          end
        end
      end
    end
  end

  assign rd_addr = cmd.idx[LOG2N-1:0];
  assign rd_re   = re_r[rd_addr];
  assign rd_im   = im_r[rd_addr];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      re_r[wr_addr] <= IW'(sample_real);
      im_r[wr_addr] <= IW'(sample_imag);
    end else if (cmd.add) begin
      for (int p = 0; p < POINTS; p++) begin
        re_r[p] <= re_nxt[p];
        im_r[p] <= im_nxt[p];
      end
    end
    if (cmd.mul) begin
      for (int p = 0; p < POINTS; p++) begin
        tre_r[p] <= tre_nxt[p];
        tim_r[p] <= tim_nxt[p];
      end
    end
    if (cmd.emit) begin
      bin_real_r  <= sat_bin(rd_re);
      bin_imag_r  <= sat_bin(rd_im);
      bin_index_r <= cmd.idx;
      last_bin_r  <= (cmd.idx == LAST_IDX);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign bin_real     = bin_real_r;
  assign bin_imag     = bin_imag_r;
  assign bin_index    = bin_index_r;
  assign last_bin     = last_bin_r;

endmodule

// ----- src/fft_radix2_8point_unit.sv -----
`timescale 1ns / 1ps
// Forward radix-2 decimation-in-time FFT over frames of POINTS (2, 4 or 8) complex
// samples, unscaled, with bins three bits wider than the samples and saturated at
// that width. Samples enter one per cycle in natural order; after the last sample of
// a frame the butterflies run one stage at a time, each as twiddle products, then
// add and subtract, and the bins leave in natural order, one per cycle while the
// sink keeps ready high, with last_bin set on the final one. The input is not
// taken during the transform and while bins are being handed out. The next frame
// is taken as soon as the last bin sits in the output register.
module fft_radix2_8point_unit
  import fftr2_pkg::*;
#(
  parameter int POINTS       = 8,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  fftr2_sample_if.sink          in_smp,
  fftr2_bin_if.source           out_bin
);

  fftr2_cmd_t cmd;
  fftr2_sts_t sts;

  fftr2_ctrl #(
    .POINTS(POINTS)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_smp.valid),
    .in_ready(in_smp.ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  fftr2_datapath #(
    .POINTS      (POINTS),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .sample_real(in_smp.sample_real),
    .sample_imag(in_smp.sample_imag),
    .out_valid  (out_bin.valid),
    .out_ready  (out_bin.ready),
    .bin_real   (out_bin.bin_real),
    .bin_imag   (out_bin.bin_imag),
    .bin_index  (out_bin.bin_index),
    .last_bin   (out_bin.last_bin)
  );

endmodule

// ----- sim/fft_bin_checker.sv -----
`timescale 1ns / 1ps
module fft_bin_checker
  import fftr2_pkg::*;
#(
  parameter int SAMPLE_W = 16,
  parameter int BIN_W    = 19
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_real,
  input  logic signed [SAMPLE_W-1:0] in_imag,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic signed [BIN_W-1:0]    out_real,
  input  logic signed [BIN_W-1:0]    out_imag,
  input  logic [IDX_W-1:0]           out_index,
  input  logic                       out_last,
  output int                         error_count,
  output int                         bins_pending,
  output int                         bins_checked
);

  localparam int     FRAME_LEN = 8;
  localparam longint BIN_MAX   = (64'sd1 <<< (BIN_W - 1)) - 1;
  localparam longint BIN_MIN   = -BIN_MAX - 1;

  typedef struct packed {
    logic signed [BIN_W-1:0] re;
    logic signed [BIN_W-1:0] im;
    logic [IDX_W-1:0]        index;
    logic                    last;
  } fft_bin_t;

  fft_bin_t expected_bins[$];
  longint   frame_re[FRAME_LEN];
  longint   frame_im[FRAME_LEN];
  int       samples_held;

  // Q15 product with 1/sqrt2, rounded to nearest with ties upward.
  function automatic longint q15_scale(longint s);
    return (s * longint'(TWIDDLE_Q15) + longint'(ROUND_HALF)) >>> FRAC_BITS;
  endfunction

  function automatic logic signed [BIN_W-1:0] clamp_bin(longint v);
    if (v > BIN_MAX) return BIN_W'(BIN_MAX);
    if (v < BIN_MIN) return BIN_W'(BIN_MIN);
    return BIN_W'(v);
  endfunction

  task automatic rotate(input fftr2_tw_t tw, input longint r, input longint i,
                        output longint rot_r, output longint rot_i);
    case (tw)
      TW_ONE: begin
        rot_r = r;
        rot_i = i;
      end
      TW_C1: begin
        rot_r = q15_scale(r + i);
        rot_i = q15_scale(i - r);
      end
      TW_NEG_J: begin
        rot_r = i;
        rot_i = -r;
      end
      TW_C3: begin
        rot_r = q15_scale(i - r);
        rot_i = q15_scale(-r - i);
      end
    endcase
  endtask

  task automatic compute_frame_bins();
    longint     xr[FRAME_LEN];
    longint     xi[FRAME_LEN];
    longint     tr;
    longint     ti;
    int         a;
    int         b;
    logic [2:0] nb;
    logic [1:0] tw_code;
    fft_bin_t   rec;
    for (int n = 0; n < FRAME_LEN; n++) begin
      nb = 3'(n);
      xr[n] = frame_re[{nb[0], nb[1], nb[2]}];
      xi[n] = frame_im[{nb[0], nb[1], nb[2]}];
    end
    for (int half = 1; half < FRAME_LEN; half = half * 2) begin
      for (int start = 0; start < FRAME_LEN; start += 2 * half) begin
        for (int j = 0; j < half; j++) begin
          a = start + j;
          b = a + half;
          tw_code = 2'((j * 4) / half);
          rotate(fftr2_tw_t'(tw_code), xr[b], xi[b], tr, ti);
          xr[b] = xr[a] - tr;
          xi[b] = xi[a] - ti;
          xr[a] = xr[a] + tr;
          xi[a] = xi[a] + ti;
        end
      end
    end
    for (int k = 0; k < FRAME_LEN; k++) begin
      rec.re    = clamp_bin(xr[k]);
      rec.im    = clamp_bin(xi[k]);
      rec.index = IDX_W'(k);
      rec.last  = (k == FRAME_LEN - 1);
      expected_bins.push_back(rec);
    end
  endtask

  initial begin
    error_count  = 0;
    bins_pending = 0;
    bins_checked = 0;
    samples_held = 0;
  end

  always @(posedge clk) begin
    fft_bin_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        bins_checked++;
        if (expected_bins.size() == 0) begin
          error_count++;
          $display("%0t: bin with no frame pending: re=%0d im=%0d idx=%0d last=%0b",
                   $time, out_real, out_imag, out_index, out_last);
        end else begin
          want = expected_bins.pop_front();
          if (want.re !== out_real || want.im !== out_imag ||
              want.index !== out_index || want.last !== out_last) begin
            error_count++;
            $display("%0t: bin mismatch: expected re=%0d im=%0d idx=%0d last=%0b, actual re=%0d im=%0d idx=%0d last=%0b",
                     $time, want.re, want.im, want.index, want.last,
                     out_real, out_imag, out_index, out_last);
          end
        end
      end
      // Each accepted request adds one sample; the eighth closes the frame.
      if (in_valid && in_ready) begin
        frame_re[samples_held] = longint'(in_real);
        frame_im[samples_held] = longint'(in_imag);
        samples_held++;
        if (samples_held == FRAME_LEN) begin
          compute_frame_bins();
          samples_held = 0;
        end
      end
      bins_pending = expected_bins.size();
    end
  end

endmodule

// ----- sim/tb_fft_radix2_8point_unit.sv -----
`timescale 1ns / 1ps
module tb_fft_radix2_8point_unit;
  import fftr2_pkg::*;

  localparam int SAMPLE_W  = 16;
  localparam int BIN_W     = 19;
  localparam int FRAME_LEN = 8;

  typedef enum int {
    MIX_FULL,
    MIX_SMALL,
    MIX_EDGE
  } sample_mix_t;

  logic clk;
  logic rst_n;
  int   tx_idle_pct;
  int   rx_idle_pct;
  logic long_stall_req;
  int   samples_sent;
  int   frames_sent;
  int   error_count;
  int   bins_pending;
  int   bins_checked;

  fftr2_sample_if #(.SAMPLE_WIDTH(SAMPLE_W)) smp_if ();
  fftr2_bin_if #(.BIN_WIDTH(BIN_W)) bin_if ();

  fft_radix2_8point_unit #(
    .POINTS      (FRAME_LEN),
    .SAMPLE_WIDTH(SAMPLE_W)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_smp (smp_if),
    .out_bin(bin_if)
  );

  fft_bin_checker #(
    .SAMPLE_W(SAMPLE_W),
    .BIN_W   (BIN_W)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (smp_if.valid),
    .in_ready    (smp_if.ready),
    .in_real     (smp_if.sample_real),
    .in_imag     (smp_if.sample_imag),
    .out_valid   (bin_if.valid),
    .out_ready   (bin_if.ready),
    .out_real    (bin_if.bin_real),
    .out_imag    (bin_if.bin_imag),
    .out_index   (bin_if.bin_index),
    .out_last    (bin_if.last_bin),
    .error_count (error_count),
    .bins_pending(bins_pending),
    .bins_checked(bins_checked)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #400000;
    $display("Timed out with %0d bins still expected.", bins_pending);
    $display("fft_radix2_8point_unit: mismatch");
    $finish;
  end

  // Receiver: random ready, plus one long hold-off so the block backs up
  // and stops taking samples.
  initial begin
    int  stall_left;
    bit  stall_taken;
    stall_left  = 0;
    stall_taken = 1'b0;
    bin_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        bin_if.ready <= 1'b0;
        stall_left--;
      end else if (long_stall_req && !stall_taken) begin
        stall_taken = 1'b1;
        stall_left  = 79;
        bin_if.ready <= 1'b0;
      end else begin
        bin_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] pick_part(sample_mix_t mix);
    int v;
    case (mix)
      MIX_SMALL: begin
        v = int'($urandom_range(0, 64)) - 32;
        return SAMPLE_W'(v);
      end
      MIX_EDGE: begin
        case ($urandom_range(0, 3))
          0: return 16'sd32767;
          1: return -16'sd32768;
          2: return 16'sd0;
          default: return -16'sd1;
        endcase
      end
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] re,
                             input logic signed [SAMPLE_W-1:0] im);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      smp_if.valid <= 1'b0;
      @(posedge clk);
    end
    smp_if.valid       <= 1'b1;
    smp_if.sample_real <= re;
    smp_if.sample_imag <= im;
    do @(posedge clk); while (!smp_if.ready);
    samples_sent++;
    if (samples_sent % FRAME_LEN == 0) frames_sent++;
  endtask

  task automatic send_random_frame();
    sample_mix_t mix;
    case ($urandom_range(0, 3))
      2: mix = MIX_SMALL;
      3: mix = MIX_EDGE;
      default: mix = MIX_FULL;
    endcase
    repeat (FRAME_LEN) send_sample(pick_part(mix), pick_part(mix));
  endtask

  initial begin
    // Full-scale samples at 45 degree steps line up in bin 1 and push
    // it past the output range.
    logic signed [SAMPLE_W-1:0] rot_re[FRAME_LEN];
    logic signed [SAMPLE_W-1:0] rot_im[FRAME_LEN];
    rot_re = '{16'sd32767, 16'sd32767, 16'sd0, -16'sd32767,
               -16'sd32767, -16'sd32767, 16'sd0, 16'sd32767};
    rot_im = '{16'sd0, 16'sd32767, 16'sd32767, 16'sd32767,
               16'sd0, -16'sd32767, -16'sd32767, -16'sd32767};
    rst_n              = 1'b0;
    smp_if.valid       = 1'b0;
    smp_if.sample_real = '0;
    smp_if.sample_imag = '0;
    tx_idle_pct        = 22;
    rx_idle_pct        = 52;
    long_stall_req     = 1'b0;
    samples_sent       = 0;
    frames_sent        = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int n = 0; n < FRAME_LEN; n++) begin
      send_sample(n[0] ? -16'sd32768 : 16'sd32767, n[1] ? 16'sd32767 : -16'sd32768);
    end
    for (int n = 0; n < FRAME_LEN; n++) send_sample(rot_re[n], rot_im[n]);
    for (int n = 0; n < FRAME_LEN; n++) send_sample(~rot_re[n], ~rot_im[n]);

    repeat (7) send_random_frame();
    tx_idle_pct = 52;
    rx_idle_pct = 22;
    repeat (7) send_random_frame();
    tx_idle_pct    = 0;
    rx_idle_pct    = 0;
    long_stall_req = 1'b1;
    repeat (6) send_random_frame();
    smp_if.valid <= 1'b0;

    do @(negedge clk); while (bins_pending != 0);
    repeat (30) @(posedge clk);
    $display("Streamed %0d samples in %0d frames, including full-scale and saturating frames.",
             samples_sent, frames_sent);
    $display("Compared %0d bins under random stalls on both sides and one long output hold-off.",
             bins_checked);
    if (error_count == 0) begin
      $display("fft_radix2_8point_unit: match");
    end else begin
      $display("fft_radix2_8point_unit: mismatch");
    end
    $finish;
  end

endmodule
